### hw/rtl/bvsq_pkg.sv
`timescale 1ns / 1ps

package bvsq_pkg;

  // default sample width
  localparam int MV_BITS_DEF = 13;

  // fixed field widths
  localparam int CFG_W      = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CNT_W      = 3;
  localparam int STREAK_W   = 4;
  localparam int REP_W      = 14;
  localparam int PCT_W      = 8;
  localparam int PCT_Q_W    = 7;
  // (full - empty) * 100 fits in this many bits
  localparam int PCT_NUM_W  = 20;

  localparam logic [STREAK_W-1:0] STREAK_MAX = 4'd15;
  localparam logic [PCT_W-1:0]    PCT_FULL   = 8'd100;
  localparam logic [PCT_W-1:0]    PCT_ZERO   = 8'd0;
  localparam logic [PCT_W-1:0]    PCT_NONE   = 8'hFF;
  localparam logic [REP_W-1:0]    REP_NONE   = 14'h3FFF;

  // register reset values
  localparam logic [CFG_W-1:0]    RST_PLAUSIBLE_FLOOR = 13'd3300;
  localparam logic [CFG_W-1:0]    RST_SUSPECT_DROP    = 13'd300;
  localparam logic [CFG_W-1:0]    RST_AGREE_TOL       = 13'd150;
  localparam logic [STREAK_W-1:0] RST_REQ_AGREE       = 4'd3;
  localparam logic [CFG_W-1:0]    RST_EMPTY           = 13'd3300;
  localparam logic [CFG_W-1:0]    RST_FULL            = 13'd4200;
  localparam logic [CNT_W-1:0]    RST_MAX_SAMPLES     = 3'd5;
  localparam logic [CNT_W-1:0]    RST_NEEDED_PLAUS    = 3'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PLAUSIBLE_FLOOR = 3'd0,
    CFG_SUSPECT_DROP    = 3'd1,
    CFG_AGREE_TOL       = 3'd2,
    CFG_REQ_AGREE       = 3'd3,
    CFG_EMPTY           = 3'd4,
    CFG_FULL            = 3'd5,
    CFG_MAX_SAMPLES     = 3'd6,
    CFG_NEEDED_PLAUS    = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0]    plausible_floor_mv;
    logic [CFG_W-1:0]    suspect_drop_mv;
    logic [CFG_W-1:0]    agree_tolerance_mv;
    logic [STREAK_W-1:0] required_agreements;
    logic [CFG_W-1:0]    empty_mv;
    logic [CFG_W-1:0]    full_mv;
    logic [CNT_W-1:0]    max_samples;
    logic [CNT_W-1:0]    needed_plausible;
  } cfg_t;

  typedef struct packed {
    logic rep_valid;
    logic fresh;
    logic pending;
  } qual_flags_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MEAN,
    ST_QUAL,
    ST_PCT,
    ST_PDIV,
    ST_OUT
  } state_t;

endpackage

### hw/rtl/bvsq_cfg.sv
`timescale 1ns / 1ps

module bvsq_cfg (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 wr_en,
  input  logic [bvsq_pkg::CFG_IDX_W-1:0]       wr_index,
  input  logic [bvsq_pkg::CFG_W-1:0]           wr_data,
  output bvsq_pkg::cfg_t                       cfg
);

  bvsq_pkg::cfg_idx_t idx;

  assign idx = bvsq_pkg::cfg_idx_t'(wr_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.plausible_floor_mv  <= bvsq_pkg::RST_PLAUSIBLE_FLOOR;
      cfg.suspect_drop_mv     <= bvsq_pkg::RST_SUSPECT_DROP;
      cfg.agree_tolerance_mv  <= bvsq_pkg::RST_AGREE_TOL;
      cfg.required_agreements <= bvsq_pkg::RST_REQ_AGREE;
      cfg.empty_mv            <= bvsq_pkg::RST_EMPTY;
      cfg.full_mv             <= bvsq_pkg::RST_FULL;
      cfg.max_samples         <= bvsq_pkg::RST_MAX_SAMPLES;
      cfg.needed_plausible    <= bvsq_pkg::RST_NEEDED_PLAUS;
    end else if (wr_en) begin
      unique case (idx)
        bvsq_pkg::CFG_PLAUSIBLE_FLOOR: cfg.plausible_floor_mv <= wr_data;
        bvsq_pkg::CFG_SUSPECT_DROP:    cfg.suspect_drop_mv <= wr_data;
        bvsq_pkg::CFG_AGREE_TOL:       cfg.agree_tolerance_mv <= wr_data;
        bvsq_pkg::CFG_REQ_AGREE:
          cfg.required_agreements <= wr_data[bvsq_pkg::STREAK_W-1:0];
        bvsq_pkg::CFG_EMPTY:           cfg.empty_mv <= wr_data;
        bvsq_pkg::CFG_FULL:            cfg.full_mv <= wr_data;
        bvsq_pkg::CFG_MAX_SAMPLES:
          cfg.max_samples <= wr_data[bvsq_pkg::CNT_W-1:0];
        bvsq_pkg::CFG_NEEDED_PLAUS:
          cfg.needed_plausible <= wr_data[bvsq_pkg::CNT_W-1:0];
      endcase
    end
  end

endmodule

### hw/rtl/bvsq_div.sv
`timescale 1ns / 1ps

// bit-serial restoring divider, one dividend bit per cycle
module bvsq_div #(
  parameter int DW = 20,
  parameter int VW = 13
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CNTW = $clog2(DW + 1);

  logic [VW-1:0]   rem;
  logic [DW-1:0]   quo;
  logic [VW-1:0]   dsr;
  logic [CNTW-1:0] cnt;
  logic            busy;
  logic [VW:0]     trial;
  logic [VW:0]     trial_sub;
  logic            trial_ge;

  assign trial     = {rem, quo[DW-1]};
  assign trial_ge  = trial >= {1'b0, dsr};
  assign trial_sub = trial - {1'b0, dsr};
  assign quotient  = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNTW'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNTW'(DW);
      end else if (busy) begin
        cnt <= cnt - CNTW'(1);
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      rem <= trial_ge ? trial_sub[VW-1:0] : trial[VW-1:0];
      quo <= {quo[DW-2:0], trial_ge};
    end
  end

endmodule

### hw/rtl/bvsq_qual.sv
`timescale 1ns / 1ps

// confirmed / pending drop tracking
module bvsq_qual #(
  parameter int MV_BITS = bvsq_pkg::MV_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      apply,
  input  logic                      raw_valid,
  input  logic [MV_BITS-1:0]        raw_mv,
  input  bvsq_pkg::cfg_t            cfg,
  output logic [MV_BITS-1:0]        rep_mv,
  output bvsq_pkg::qual_flags_t     flags
);

  localparam int CW = (MV_BITS > bvsq_pkg::CFG_W) ? MV_BITS : bvsq_pkg::CFG_W;
  localparam int WW = CW + 2;

  logic                          conf_valid;
  logic [MV_BITS-1:0]            conf_mv;
  logic                          pend_valid;
  logic [MV_BITS-1:0]            pend_mv;
  logic [bvsq_pkg::STREAK_W-1:0] streak;

  logic                          conf_valid_next;
  logic [MV_BITS-1:0]            conf_mv_next;
  logic                          pend_valid_next;
  logic [MV_BITS-1:0]            pend_mv_next;
  logic [bvsq_pkg::STREAK_W-1:0] streak_next;

  logic signed [WW-1:0]          drop;
  logic signed [WW-1:0]          drop_limit;
  logic                          drop_small;
  logic [MV_BITS-1:0]            abs_diff;
  logic                          agree;
  logic [bvsq_pkg::STREAK_W-1:0] streak_inc;
  logic                          confirm_late;

  assign drop       = $signed(WW'(conf_mv)) - $signed(WW'(raw_mv));
  assign drop_limit = $signed(WW'(cfg.suspect_drop_mv));
  assign drop_small = !conf_valid || (drop < drop_limit);
  assign abs_diff   = (raw_mv >= pend_mv) ? (raw_mv - pend_mv) : (pend_mv - raw_mv);
  assign agree      = pend_valid && (CW'(abs_diff) < CW'(cfg.agree_tolerance_mv));
  assign streak_inc = !agree ? bvsq_pkg::STREAK_W'(1) :
                      (streak == bvsq_pkg::STREAK_MAX) ? streak :
                      streak + bvsq_pkg::STREAK_W'(1);
  assign confirm_late = streak_inc >= cfg.required_agreements;

  always_comb begin
    conf_valid_next = conf_valid;
    conf_mv_next    = conf_mv;
    pend_valid_next = pend_valid;
    pend_mv_next    = pend_mv;
    streak_next     = streak;
    rep_mv          = conf_mv;
    flags.rep_valid = conf_valid;
    flags.fresh     = 1'b0;
    if (raw_valid) begin
      if (drop_small || confirm_late) begin
        conf_valid_next = 1'b1;
        conf_mv_next    = raw_mv;
        pend_valid_next = 1'b0;
        streak_next     = '0;
        rep_mv          = raw_mv;
        flags.rep_valid = 1'b1;
        flags.fresh     = 1'b1;
      end else begin
        // suspect drop: either agrees with pending or restarts it
        pend_valid_next = 1'b1;
        pend_mv_next    = agree ? pend_mv : raw_mv;
        streak_next     = streak_inc;
      end
    end
    flags.pending = pend_valid_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      conf_valid <= 1'b0;
      pend_valid <= 1'b0;
      streak     <= '0;
    end else if (apply) begin
      conf_valid <= conf_valid_next;
      pend_valid <= pend_valid_next;
      streak     <= streak_next;
    end
  end

  always_ff @(posedge clk) begin
    if (apply) begin
      conf_mv <= conf_mv_next;
      pend_mv <= pend_mv_next;
    end
  end

endmodule

### hw/rtl/battery_voltage_sag_qualifier.sv
`timescale 1ns / 1ps

// channel   dir  handshake              payload
// s_*       in   s_tvalid / s_tready    s_tdata: sample_mv
// m_*       out  m_tvalid / m_tready    m_tdata: reported_mv, percent,
//                                                newly_confirmed, drop_pending
// cfg_*     in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// a sample that does not close a measurement leaves the sequencer in the idle state.
// a closing sample runs the sequencer through the shared bit-serial divider:
// one pass for the mean and one for the percentage; a measurement without
// plausible samples skips the first pass, and percent outside the span skips the second.
// s_tready is high only in the idle state; a finished item waits in the output
// register, and a stalled m_tready holds the sequencer before it returns to idle.
// rst is synchronous; cfg_ready is always high.
module battery_voltage_sag_qualifier #(
  parameter int MV_BITS = bvsq_pkg::MV_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [((MV_BITS + 7) / 8) * 8-1:0]  s_tdata,   // sample_mv
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // reported_mv[13:0], percent[21:14], newly_confirmed[22], drop_pending[23]
  output logic [23:0]                         m_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bvsq_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bvsq_pkg::CFG_W-1:0]          cfg_data
);

  localparam int SUMW = MV_BITS + 3;
  localparam int DW   = (SUMW > bvsq_pkg::PCT_NUM_W) ? SUMW : bvsq_pkg::PCT_NUM_W;
  localparam int CW   = (MV_BITS > bvsq_pkg::CFG_W) ? MV_BITS : bvsq_pkg::CFG_W;
  localparam int EW   = (MV_BITS > bvsq_pkg::REP_W) ? MV_BITS : bvsq_pkg::REP_W;

  bvsq_pkg::cfg_t        cfg;
  bvsq_pkg::state_t      state;
  bvsq_pkg::state_t      state_next;
  bvsq_pkg::qual_flags_t qflags;

  // measurement accumulation
  logic [bvsq_pkg::CNT_W-1:0] sample_count;
  logic [bvsq_pkg::CNT_W-1:0] plausible_count;
  logic [SUMW-1:0]            plausible_sum;
  logic                       best_valid;
  logic [MV_BITS-1:0]         best_sample;

  logic [MV_BITS-1:0]         smp;
  logic                       smp_nz;
  logic                       smp_plaus;
  logic                       best_take;
  logic [bvsq_pkg::CNT_W-1:0] sc_next;
  logic [bvsq_pkg::CNT_W-1:0] pc_next;
  logic [SUMW-1:0]            sum_next;
  logic                       close;
  logic                       in_acc;

  // per measurement result
  logic                       raw_valid;
  logic [MV_BITS-1:0]         raw_mv;
  logic [MV_BITS-1:0]         qual_mv;
  logic                       rep_valid;
  logic [MV_BITS-1:0]         rep_mv;
  logic                       rep_fresh;
  logic                       rep_pend;
  logic [bvsq_pkg::PCT_W-1:0] pct;

  logic                       rep_ge_full;
  logic                       rep_le_empty;
  logic                       pct_need_div;
  logic [CW-1:0]              pct_span;
  logic [DW-1:0]              pct_num;
  logic [bvsq_pkg::CFG_W-1:0] pct_den;
  logic [EW-1:0]              rep_ext;

  // shared divider
  logic                       div_start;
  logic [DW-1:0]              div_dividend;
  logic [bvsq_pkg::CFG_W-1:0] div_divisor;
  logic                       div_done;
  logic [DW-1:0]              div_quo;

  logic                       qual_apply;
  logic                       out_free;
  logic                       out_load;

  logic [bvsq_pkg::REP_W-1:0] out_mv;
  logic [bvsq_pkg::PCT_W-1:0] out_pct;
  logic                       out_fresh;
  logic                       out_pend;

  assign cfg_ready = 1'b1;
  assign m_tdata   = {out_pend, out_fresh, out_pct, out_mv};

  bvsq_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  bvsq_div #(
    .DW (DW),
    .VW (bvsq_pkg::CFG_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  bvsq_qual #(
    .MV_BITS (MV_BITS)
  ) u_qual (
    .clk       (clk),
    .rst       (rst),
    .apply     (qual_apply),
    .raw_valid (raw_valid),
    .raw_mv    (raw_mv),
    .cfg       (cfg),
    .rep_mv    (qual_mv),
    .flags     (qflags)
  );

  // sample bookkeeping
  assign smp       = s_tdata[MV_BITS-1:0];
  assign smp_nz    = |smp;
  assign smp_plaus = smp_nz && (CW'(smp) >= CW'(cfg.plausible_floor_mv));
  assign best_take = smp_nz && (!best_valid || (smp > best_sample));
  assign sc_next   = sample_count + bvsq_pkg::CNT_W'(1);
  assign pc_next   = plausible_count + bvsq_pkg::CNT_W'(smp_plaus);
  assign sum_next  = plausible_sum + (smp_plaus ? SUMW'(smp) : SUMW'(0));
  assign close     = !((sc_next < cfg.max_samples) && (pc_next < cfg.needed_plausible));
  assign in_acc    = s_tvalid && s_tready;

  // percent path
  assign rep_ge_full  = CW'(rep_mv) >= CW'(cfg.full_mv);
  assign rep_le_empty = CW'(rep_mv) <= CW'(cfg.empty_mv);
  assign pct_need_div = rep_valid && !rep_ge_full && !rep_le_empty;
  assign pct_span     = CW'(rep_mv) - CW'(cfg.empty_mv);
  assign pct_num      = DW'(pct_span[bvsq_pkg::CFG_W-1:0]) * DW'(bvsq_pkg::PCT_FULL);
  assign pct_den      = cfg.full_mv - cfg.empty_mv;
  assign rep_ext      = EW'(rep_mv);

  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    unique case (state)
      bvsq_pkg::ST_IDLE: begin
        if (in_acc && close) begin
          state_next = (pc_next != '0) ? bvsq_pkg::ST_MEAN : bvsq_pkg::ST_QUAL;
        end
      end
      bvsq_pkg::ST_MEAN: begin
        if (div_done) begin
          state_next = bvsq_pkg::ST_QUAL;
        end
      end
      bvsq_pkg::ST_QUAL: state_next = bvsq_pkg::ST_PCT;
      bvsq_pkg::ST_PCT: begin
        state_next = pct_need_div ? bvsq_pkg::ST_PDIV : bvsq_pkg::ST_OUT;
      end
      bvsq_pkg::ST_PDIV: begin
        if (div_done) begin
          state_next = bvsq_pkg::ST_OUT;
        end
      end
      bvsq_pkg::ST_OUT: begin
        if (out_free) begin
          state_next = bvsq_pkg::ST_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    s_tready     = 1'b0;
    div_start    = 1'b0;
    qual_apply   = 1'b0;
    out_load     = 1'b0;
    div_dividend = DW'(sum_next);
    div_divisor  = bvsq_pkg::CFG_W'(pc_next);
    unique case (state)
      bvsq_pkg::ST_IDLE: begin
        s_tready  = 1'b1;
        div_start = in_acc && close && (pc_next != '0);
      end
      bvsq_pkg::ST_MEAN: ;
      bvsq_pkg::ST_QUAL: qual_apply = 1'b1;
      bvsq_pkg::ST_PCT: begin
        div_start    = pct_need_div;
        div_dividend = pct_num;
        div_divisor  = pct_den;
      end
      bvsq_pkg::ST_PDIV: ;
      bvsq_pkg::ST_OUT: out_load = out_free;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bvsq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count    <= '0;
      plausible_count <= '0;
      plausible_sum   <= '0;
      best_valid      <= 1'b0;
    end else if (in_acc) begin
      if (close) begin
        sample_count    <= '0;
        plausible_count <= '0;
        plausible_sum   <= '0;
        best_valid      <= 1'b0;
      end else begin
        sample_count    <= sc_next;
        plausible_count <= pc_next;
        plausible_sum   <= sum_next;
        best_valid      <= best_valid || best_take;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && best_take) begin
      best_sample <= smp;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && close) begin
      // without plausible samples the best sample stands in
      raw_valid <= best_valid || best_take;
      raw_mv    <= best_take ? smp : best_sample;
    end else if (state == bvsq_pkg::ST_MEAN && div_done) begin
      raw_valid <= 1'b1;
      raw_mv    <= div_quo[MV_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (qual_apply) begin
      rep_valid <= qflags.rep_valid;
      rep_mv    <= qual_mv;
      rep_fresh <= qflags.fresh;
      rep_pend  <= qflags.pending;
    end
    if (state == bvsq_pkg::ST_PCT) begin
      priority if (!rep_valid) begin
        pct <= bvsq_pkg::PCT_NONE;
      end else if (rep_ge_full) begin
        pct <= bvsq_pkg::PCT_FULL;
      end else begin
        pct <= bvsq_pkg::PCT_ZERO;
      end
    end else if (state == bvsq_pkg::ST_PDIV && div_done) begin
      pct <= {1'b0, div_quo[bvsq_pkg::PCT_Q_W-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_mv    <= rep_valid ? rep_ext[bvsq_pkg::REP_W-1:0] : bvsq_pkg::REP_NONE;
      out_pct   <= pct;
      out_fresh <= rep_fresh;
      out_pend  <= rep_pend;
    end
  end

`ifndef ASSERT_OFF
  a_pct_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[21:14] == bvsq_pkg::PCT_NONE) ||
                 (m_tdata[21:14] <= bvsq_pkg::PCT_FULL))
    else $error("percent out of range");

  a_pct_none: assert property (@(posedge clk) disable iff (rst)
    state == bvsq_pkg::ST_OUT |-> rep_valid == (pct != bvsq_pkg::PCT_NONE))
    else $error("percent none does not match missing voltage");

  a_fresh_pend: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[22] && m_tdata[23]))
    else $error("confirmed item still shows a pending drop");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == bvsq_pkg::ST_MEAN) || (state == bvsq_pkg::ST_PDIV))
    else $error("divider finished outside a divide state");

  a_load_ready: assert property (@(posedge clk) disable iff (rst)
    (state == bvsq_pkg::ST_QUAL) |=> (state == bvsq_pkg::ST_PCT) && !s_tready)
    else $error("sequencer left qualify step early");
`endif

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import bvsq_pkg::*;

  localparam int MV_W         = MV_BITS_DEF;
  localparam int SDATA_W      = ((MV_W + 7) / 8) * 8;
  localparam int MV_MAX       = (1 << MV_W) - 1;
  localparam int DRAIN_CYCLES = 80;
  localparam int LONG_HOLD    = 400;
  localparam int RUN_LIMIT    = 600000;
  localparam int PRINT_LIMIT  = 100;
  localparam int RAND_PHASES  = 12;
  localparam int PHASE_ITEMS  = 150;

  // packed to match m_tdata, reported_mv in the low bits
  typedef struct packed {
    logic             drop_pending;
    logic             newly_confirmed;
    logic [PCT_W-1:0] percent;
    logic [REP_W-1:0] reported_mv;
  } sag_report_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [SDATA_W-1:0] s_tdata = '0;     // sample_mv
  logic               m_tvalid;
  logic               m_tready = 1'b1;
  logic [23:0]        m_tdata;          // reported_mv, percent, newly_confirmed, drop_pending
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  cfg_idx_t           cfg_index = CFG_PLAUSIBLE_FLOOR;
  logic [CFG_W-1:0]   cfg_data = '0;

  battery_voltage_sag_qualifier DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // qualifier model state
  cfg_t        cfg_m;
  int          n_samples, n_plaus, plaus_sum, best_mv;
  int          confirmed_mv, suspect_mv, streak;
  sag_report_t reports_due[$];

  logic [MV_W-1:0] samples_q[$];
  int  cycle_count = 0;
  int  cfg_writes_seen = 0;
  int  mismatches = 0;
  bit  in_took = 1'b0;
  bit  jitter_on = 1'b0;
  int  send_gap = 0;
  int  stall_left = 0;
  int  hold_left = 0;
  int  hold_req = 0;
  int  hold_seen = 0;

  // settings planned for the current phase
  int p_floor, p_drop, p_tol, p_req, p_empty, p_full, p_max, p_need;
  int sag_level = 3900;

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= PRINT_LIMIT)
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
  endtask

  function automatic int clamp_mv(input int v);
    if (v < 0) return 0;
    if (v > MV_MAX) return MV_MAX;
    return v;
  endfunction

  function automatic void take_value(input int v);
    confirmed_mv = v;
    suspect_mv   = -1;
    streak       = 0;
  endfunction

  // accumulate one sample; a closing sample queues the qualified report
  task automatic qualify_sample(input logic [MV_W-1:0] raw_sample);
    int          smp, val, pct, d;
    sag_report_t r;
    smp = int'(raw_sample);
    n_samples++;
    if (smp > 0) begin
      if (smp > best_mv) best_mv = smp;
      if (smp >= int'(cfg_m.plausible_floor_mv)) begin
        plaus_sum += smp;
        n_plaus++;
      end
    end
    if (n_samples < int'(cfg_m.max_samples) && n_plaus < int'(cfg_m.needed_plausible))
      return;
    val = (n_plaus > 0) ? plaus_sum / n_plaus : best_mv;
    n_samples = 0;
    n_plaus   = 0;
    plaus_sum = 0;
    best_mv   = -1;
    r.newly_confirmed = 1'b0;
    if (val > 0) begin
      if (confirmed_mv <= 0 || confirmed_mv - val < int'(cfg_m.suspect_drop_mv)) begin
        take_value(val);
        r.newly_confirmed = 1'b1;
      end else begin
        d = (suspect_mv > 0) ? val - suspect_mv : 0;
        if (d < 0) d = -d;
        if (suspect_mv > 0 && d < int'(cfg_m.agree_tolerance_mv)) begin
          if (streak < int'(STREAK_MAX)) streak++;
        end else begin
          suspect_mv = val;
          streak     = 1;
        end
        if (streak >= int'(cfg_m.required_agreements)) begin
          take_value(val);
          r.newly_confirmed = 1'b1;
        end
      end
    end
    if (confirmed_mv < 0)
      pct = -1;
    else if (confirmed_mv >= int'(cfg_m.full_mv))
      pct = 100;
    else if (confirmed_mv <= int'(cfg_m.empty_mv))
      pct = 0;
    else
      pct = (confirmed_mv - int'(cfg_m.empty_mv)) * 100 /
            (int'(cfg_m.full_mv) - int'(cfg_m.empty_mv));
    r.reported_mv  = confirmed_mv[REP_W-1:0];
    r.percent      = pct[PCT_W-1:0];
    r.drop_pending = (suspect_mv > 0);
    reports_due.push_back(r);
  endtask

  // sample, predict and check at the rising edge
  always @(posedge clk) begin : observe
    sag_report_t got, want;
    cycle_count <= cycle_count + 1;
    in_took     <= !rst && s_tvalid && s_tready;
    if (rst) begin
      cfg_m.plausible_floor_mv  = RST_PLAUSIBLE_FLOOR;
      cfg_m.suspect_drop_mv     = RST_SUSPECT_DROP;
      cfg_m.agree_tolerance_mv  = RST_AGREE_TOL;
      cfg_m.required_agreements = RST_REQ_AGREE;
      cfg_m.empty_mv            = RST_EMPTY;
      cfg_m.full_mv             = RST_FULL;
      cfg_m.max_samples         = RST_MAX_SAMPLES;
      cfg_m.needed_plausible    = RST_NEEDED_PLAUS;
      n_samples = 0;
      n_plaus   = 0;
      plaus_sum = 0;
      best_mv   = -1;
      take_value(-1);
    end else begin
      if (m_tvalid && m_tready) begin
        got = sag_report_t'(m_tdata);
        if (reports_due.size() == 0) begin
          report_mismatch("result with none due, reported_mv", $signed(got.reported_mv), 0);
        end else begin
          want = reports_due.pop_front();
          if (got.reported_mv !== want.reported_mv)
            report_mismatch("reported_mv", $signed(got.reported_mv), $signed(want.reported_mv));
          if (got.percent !== want.percent)
            report_mismatch("percent", $signed(got.percent), $signed(want.percent));
          if (got.newly_confirmed !== want.newly_confirmed)
            report_mismatch("newly_confirmed", got.newly_confirmed, want.newly_confirmed);
          if (got.drop_pending !== want.drop_pending)
            report_mismatch("drop_pending", got.drop_pending, want.drop_pending);
        end
      end
      if (s_tvalid && s_tready)
        qualify_sample(s_tdata[MV_W-1:0]);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PLAUSIBLE_FLOOR: cfg_m.plausible_floor_mv  = cfg_data;
          CFG_SUSPECT_DROP:    cfg_m.suspect_drop_mv     = cfg_data;
          CFG_AGREE_TOL:       cfg_m.agree_tolerance_mv  = cfg_data;
          CFG_REQ_AGREE:       cfg_m.required_agreements = cfg_data[STREAK_W-1:0];
          CFG_EMPTY:           cfg_m.empty_mv            = cfg_data;
          CFG_FULL:            cfg_m.full_mv             = cfg_data;
          CFG_MAX_SAMPLES:     cfg_m.max_samples         = cfg_data[CNT_W-1:0];
          CFG_NEEDED_PLAUS:    cfg_m.needed_plausible    = cfg_data[CNT_W-1:0];
          default: ;
        endcase
        cfg_writes_seen <= cfg_writes_seen + 1;
      end
    end
  end

  // sample driver
  always @(negedge clk) begin : feed
    if (!rst && (!s_tvalid || in_took)) begin
      if (send_gap > 0) begin
        send_gap--;
        s_tvalid <= 1'b0;
      end else if (samples_q.size() > 0) begin
        s_tdata  <= SDATA_W'(samples_q.pop_front());
        s_tvalid <= 1'b1;
        if (jitter_on && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 8);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // result receiver, with random stalls and one long hold
  always @(negedge clk) begin : drain
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if (jitter_on && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 8);
    end
  end

  // called at a falling edge; returns at the falling edge after the write
  task automatic write_reg(input cfg_idx_t idx, input int val);
    int target;
    target = cfg_writes_seen + 1;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_W-1:0];
    do @(negedge clk); while (cfg_writes_seen != target);
  endtask

  task automatic program_settings();
    @(negedge clk);
    write_reg(CFG_PLAUSIBLE_FLOOR, p_floor);
    write_reg(CFG_SUSPECT_DROP, p_drop);
    write_reg(CFG_AGREE_TOL, p_tol);
    write_reg(CFG_REQ_AGREE, p_req);
    write_reg(CFG_EMPTY, p_empty);
    write_reg(CFG_FULL, p_full);
    write_reg(CFG_MAX_SAMPLES, p_max);
    write_reg(CFG_NEEDED_PLAUS, p_need);
    cfg_valid <= 1'b0;
  endtask

  // everything sent, every report back, then let the sequencer go idle
  task automatic wait_quiet();
    do @(negedge clk); while (samples_q.size() != 0 || s_tvalid || reports_due.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // a slowly wandering level with sags, noise, failed reads and wild values
  task automatic queue_random_samples(input int count);
    int k, r, amp, smp;
    amp = (p_tol > 300) ? 300 : p_tol;
    for (k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 3)
        sag_level = $urandom_range(1, MV_MAX);
      else if (r < 9)
        sag_level = clamp_mv(sag_level - int'($urandom_range(0, 2 * p_drop + 50)));
      else if (r < 12)
        sag_level = clamp_mv(sag_level + int'($urandom_range(0, 600)));
      r = $urandom_range(0, 99);
      if (r < 7)
        smp = 0;
      else if (r < 13)
        smp = $urandom_range(0, MV_MAX);
      else
        smp = clamp_mv(sag_level + int'($urandom_range(0, 2 * amp)) - amp);
      samples_q.push_back(smp[MV_W-1:0]);
    end
  endtask

  initial begin : main
    // reset values: mean of plausible samples, all-failed measurement, mixed samples
    int dir_reset[13] = '{4200, 4200, 4200, 0, 0, 0, 0, 0, MV_MAX, 1, 0, 3299, 3300};
    // one sample per measurement: agreeing sag, broken agreement, no value, rises
    int dir_sag[12]   = '{4200, 4210, 4205, 3900, 0, 3800, 3650, 3660, 3670, 3500, 1, MV_MAX};
    int ph;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    jitter_on = 1'b1;

    foreach (dir_reset[i]) samples_q.push_back(dir_reset[i][MV_W-1:0]);
    wait_quiet();

    p_floor = 3300; p_drop = 300; p_tol = 150; p_req = 3;
    p_empty = 3300; p_full = 4200; p_max = 1;  p_need = 1;
    program_settings();
    foreach (dir_sag[i]) samples_q.push_back(dir_sag[i][MV_W-1:0]);
    wait_quiet();

    for (ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: begin
          // all zero: every sample closes, first suspect confirms, no percent span
          p_floor = 0; p_drop = 0; p_tol = 0; p_req = 0;
          p_empty = 0; p_full = 0; p_max = 0; p_need = 0;
        end
        1: begin
          p_floor = MV_MAX; p_drop = MV_MAX; p_tol = MV_MAX; p_req = int'(STREAK_MAX);
          p_empty = MV_MAX; p_full = MV_MAX; p_max = 7; p_need = 7;
        end
        2: begin
          // full below empty
          p_floor = 3300; p_drop = 200; p_tol = 100; p_req = 2;
          p_empty = 4000; p_full = 3000; p_max = 2; p_need = 1;
        end
        3: begin
          // long streaks with loose agreement and a hair-trigger drop
          p_floor = 3000; p_drop = 1; p_tol = MV_MAX; p_req = int'(STREAK_MAX);
          p_empty = 3000; p_full = 4300; p_max = 1; p_need = 1;
        end
        4: begin
          p_floor = 3300; p_drop = 300; p_tol = 150; p_req = 3;
          p_empty = 3300; p_full = 4200; p_max = 1; p_need = 1;
        end
        default: begin
          p_floor = ($urandom_range(0, 3) == 0) ? $urandom_range(0, MV_MAX)
                                                 : $urandom_range(2800, 3800);
          p_drop  = $urandom_range(1, 800);
          p_tol   = $urandom_range(0, 400);
          p_req   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 4);
          p_empty = $urandom_range(2500, 3600);
          p_full  = p_empty + int'($urandom_range(1, 1500));
          p_max   = $urandom_range(1, 7);
          p_need  = $urandom_range(1, 7);
        end
      endcase
      jitter_on = (ph < RAND_PHASES - 2);
      sag_level = $urandom_range(3000, 4500);
      program_settings();
      queue_random_samples(PHASE_ITEMS);
      // receiver holds off while the sender keeps offering, so the block backs up
      if (ph == 4) hold_req++;
      wait_quiet();
    end

    if (reports_due.size() != 0)
      report_mismatch("results never delivered", reports_due.size(), 0);
    if (mismatches == 0)
      $display("** battery_voltage_sag_qualifier: PASSED **");
    else
      $display("** battery_voltage_sag_qualifier: FAILED **");
    $finish;
  end

  initial begin : watchdog
    wait (cycle_count >= RUN_LIMIT);
    $display("** battery_voltage_sag_qualifier: FAILED **");
    $finish;
  end

endmodule
